// ===== rtl/smoothed_spectral_coherence_unit_assert.svh =====
// assertion macros for the smoothed spectral coherence unit
// expects clk and rst_n in the scope of the including module
`ifndef SMOOTHED_SPECTRAL_COHERENCE_UNIT_ASSERT_SVH
`define SMOOTHED_SPECTRAL_COHERENCE_UNIT_ASSERT_SVH

// condition must hold at every edge out of reset
`define SSCU_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define SSCU_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/sscu_pkg.sv =====
// shared types and constants of the smoothed spectral coherence unit
// no dependencies
package sscu_pkg;

    localparam int BIN_W    = 11;
    localparam int WEIGHT_W = 16;
    localparam int COH_W    = 16;
    localparam int Q_BITS   = 15;
    localparam int QDEPTH   = 32;

    localparam logic [COH_W-1:0] ONE_Q15 = 16'd32768;

    localparam logic CFG_NEW_WEIGHT = 1'b0;
    localparam logic CFG_OLD_WEIGHT = 1'b1;

    typedef enum logic [1:0] {
        KIND_NORMAL,
        KIND_ZERO_BIN,
        KIND_IGNORE
    } kind_t;

    typedef struct packed {
        logic [BIN_W-1:0] bin;
        kind_t            kind;
        logic [COH_W-1:0] raw;
        logic             zero_power;
        logic             last;
    } item_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } back_stat_t;

endpackage

// ===== rtl/sscu_front.sv =====
// front end: accepts bins, classifies them, squares, multiplies and divides
// depends on sscu_pkg
module sscu_front #(
    parameter int FFT_SIZE = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [sscu_pkg::BIN_W-1:0]     in_bin,
    input  logic signed [31:0]             in_re,
    input  logic signed [31:0]             in_im,
    input  logic [31:0]                    in_pl,
    input  logic [31:0]                    in_pr,
    input  logic                           in_last,
    input  sscu_pkg::back_stat_t           bstat,
    output logic                           push_valid,
    output sscu_pkg::item_t                push_item
);

    localparam int HALF = FFT_SIZE / 2;
    localparam int CW   = $clog2(sscu_pkg::QDEPTH + 1);
    localparam int NS   = sscu_pkg::Q_BITS;

    logic [CW-1:0] credit_reg, credit_next;
    logic          accept;

    // stage 0: abs values and classification
    logic                          v0_reg;
    logic [sscu_pkg::BIN_W-1:0]    bin0_reg;
    sscu_pkg::kind_t               kind0_reg, kind_in;
    logic                          last0_reg;
    logic [31:0]                   re0_reg, im0_reg, pl0_reg, pr0_reg;

    // stage 1: products
    logic                          v1_reg;
    logic [sscu_pkg::BIN_W-1:0]    bin1_reg;
    sscu_pkg::kind_t               kind1_reg;
    logic                          last1_reg;
    logic [63:0]                   re2_reg, im2_reg, den1_reg;

    // stage 2: numerator and special cases
    logic                          v2_reg;
    logic [sscu_pkg::BIN_W-1:0]    bin2_reg;
    sscu_pkg::kind_t               kind2_reg;
    logic                          last2_reg;
    logic [63:0]                   num2_reg, den2_reg;
    logic                          sat2_reg, zero2_reg;

    // divider stages, one quotient bit each
    logic                          dv_reg   [NS];
    logic [sscu_pkg::BIN_W-1:0]    dbin_reg [NS];
    sscu_pkg::kind_t               dkind_reg[NS];
    logic                          dlast_reg[NS];
    logic                          dsat_reg [NS];
    logic                          dzero_reg[NS];
    logic [63:0]                   drem_reg [NS];
    logic [63:0]                   dden_reg [NS];
    logic [NS-1:0]                 dq_reg   [NS];

    logic [63:0]                   src_rem  [NS];
    logic [63:0]                   src_den  [NS];
    logic [NS-1:0]                 src_q    [NS];
    logic [63:0]                   rem_next [NS];
    logic [NS-1:0]                 q_next   [NS];
    logic [63:0]                   gap      [NS];

    assign in_ready = (credit_reg != '0) && !bstat.clearing;
    assign accept   = in_valid && in_ready;

    // a credit is one free queue slot, returned when the back end pops
    always_comb
    begin
        case ({accept, bstat.pop})
            2'b10:   credit_next = credit_reg - CW'(1);
            2'b01:   credit_next = credit_reg + CW'(1);
            default: credit_next = credit_reg;
        endcase
    end

    always_comb
    begin
        if (in_bin == '0)
            kind_in = sscu_pkg::KIND_ZERO_BIN;
        else if (17'(in_bin) < 17'(HALF))
            kind_in = sscu_pkg::KIND_NORMAL;
        else
            kind_in = sscu_pkg::KIND_IGNORE;
    end

    always_comb
    begin
        for (int k = 0; k < NS; k++)
        begin
            if (k == 0)
            begin
                src_rem[k] = num2_reg;
                src_den[k] = den2_reg;
                src_q[k]   = '0;
            end
            else
            begin
                src_rem[k] = drem_reg[k-1];
                src_den[k] = dden_reg[k-1];
                src_q[k]   = dq_reg[k-1];
            end
            gap[k] = src_den[k] - src_rem[k];
            if (src_rem[k] >= gap[k])
            begin
                rem_next[k] = src_rem[k] - gap[k];
                q_next[k]   = {src_q[k][NS-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = {src_rem[k][62:0], 1'b0};
                q_next[k]   = {src_q[k][NS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= CW'(sscu_pkg::QDEPTH);
            v0_reg     <= 1'b0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            for (int k = 0; k < NS; k++)
                dv_reg[k] <= 1'b0;
        end
        else
        begin
            credit_reg <= credit_next;
            v0_reg     <= accept;
            v1_reg     <= v0_reg;
            v2_reg     <= v1_reg;
            for (int k = 0; k < NS; k++)
                dv_reg[k] <= (k == 0) ? v2_reg : dv_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        bin0_reg  <= in_bin;
        kind0_reg <= kind_in;
        last0_reg <= in_last;
        re0_reg   <= in_re[31] ? 32'(-in_re) : 32'(in_re);
        im0_reg   <= in_im[31] ? 32'(-in_im) : 32'(in_im);
        pl0_reg   <= in_pl;
        pr0_reg   <= in_pr;

        bin1_reg  <= bin0_reg;
        kind1_reg <= kind0_reg;
        last1_reg <= last0_reg;
        re2_reg   <= 64'(re0_reg) * 64'(re0_reg);
        im2_reg   <= 64'(im0_reg) * 64'(im0_reg);
        den1_reg  <= 64'(pl0_reg) * 64'(pr0_reg);

        bin2_reg  <= bin1_reg;
        kind2_reg <= kind1_reg;
        last2_reg <= last1_reg;
        num2_reg  <= re2_reg + im2_reg;
        den2_reg  <= den1_reg;
        sat2_reg  <= (re2_reg + im2_reg) >= den1_reg;
        zero2_reg <= den1_reg == '0;

        for (int k = 0; k < NS; k++)
        begin
            dbin_reg[k]  <= (k == 0) ? bin2_reg  : dbin_reg[k-1];
            dkind_reg[k] <= (k == 0) ? kind2_reg : dkind_reg[k-1];
            dlast_reg[k] <= (k == 0) ? last2_reg : dlast_reg[k-1];
            dsat_reg[k]  <= (k == 0) ? sat2_reg  : dsat_reg[k-1];
            dzero_reg[k] <= (k == 0) ? zero2_reg : dzero_reg[k-1];
            drem_reg[k]  <= rem_next[k];
            dden_reg[k]  <= src_den[k];
            dq_reg[k]    <= q_next[k];
        end
    end

    always_comb
    begin
        push_valid           = dv_reg[NS-1];
        push_item.bin        = dbin_reg[NS-1];
        push_item.kind       = dkind_reg[NS-1];
        push_item.last       = dlast_reg[NS-1];
        push_item.zero_power = dzero_reg[NS-1];
        if (dzero_reg[NS-1])
            push_item.raw = '0;
        else if (dsat_reg[NS-1])
            push_item.raw = sscu_pkg::ONE_Q15;
        else
            push_item.raw = {1'b0, dq_reg[NS-1]};
    end

endmodule

// ===== rtl/sscu_queue.sv =====
// short queue between the front and back ends
// depends on sscu_pkg
module sscu_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sscu_pkg::item_t push_item,
    input  logic            pop,
    output logic            not_empty,
    output sscu_pkg::item_t head
);

    localparam int AW = $clog2(sscu_pkg::QDEPTH);

    sscu_pkg::item_t mem_reg [sscu_pkg::QDEPTH];
    logic [AW-1:0]   wp_reg, rp_reg;
    logic [AW:0]     cnt_reg, cnt_next;

    assign not_empty = cnt_reg != '0;
    assign head      = mem_reg[rp_reg];

    always_comb
    begin
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + (AW+1)'(1);
            2'b01:   cnt_next = cnt_reg - (AW+1)'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wp_reg <= wp_reg + AW'(1);
            if (pop)
                rp_reg <= rp_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_item;
    end

endmodule

// ===== rtl/sscu_back.sv =====
// back end: smoothed store read-modify-write and output register
// depends on sscu_pkg
module sscu_back #(
    parameter int FFT_SIZE = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  sscu_pkg::item_t                 q_item,
    input  logic [sscu_pkg::WEIGHT_W-1:0]   new_weight,
    input  logic [sscu_pkg::WEIGHT_W-1:0]   old_weight,
    output sscu_pkg::back_stat_t            bstat,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [sscu_pkg::BIN_W-1:0]      out_bin,
    output logic [sscu_pkg::COH_W-1:0]      out_coh,
    output logic                            out_zp,
    output logic                            out_last
);

    localparam int HALF  = FFT_SIZE / 2;
    localparam int DEPTH = (HALF < 2048) ? HALF : 2048;
    localparam int AW    = $clog2(DEPTH);

    logic [sscu_pkg::COH_W-1:0] store [DEPTH];

    logic                       clr_reg;
    logic [AW-1:0]              clr_addr_reg;
    logic                       back_en, pop;
    logic                       b1_v_reg;
    sscu_pkg::item_t            b1_reg;
    logic [sscu_pkg::COH_W-1:0] rd_reg, byp_reg, old_val;
    logic                       hit_reg;
    logic                       we;
    logic [AW-1:0]              waddr, raddr;
    logic [sscu_pkg::COH_W-1:0] wdata;
    logic [32:0]                acc;
    logic [16:0]                acc_sh;
    logic [sscu_pkg::COH_W-1:0] smooth;

    logic                       out_valid_reg;
    logic [sscu_pkg::BIN_W-1:0] out_bin_reg;
    logic [sscu_pkg::COH_W-1:0] out_coh_reg;
    logic                       out_zp_reg, out_last_reg;

    assign back_en        = !out_valid_reg || out_ready;
    assign pop            = back_en && q_valid && !clr_reg;
    assign bstat.pop      = pop;
    assign bstat.clearing = clr_reg;

    assign raddr   = q_item.bin[AW-1:0];
    // a write landing on the entry being read is forwarded
    assign old_val = hit_reg ? byp_reg : rd_reg;

    always_comb
    begin
        acc    = 33'(b1_reg.raw * new_weight) + 33'(old_val * old_weight);
        acc_sh = acc[32:16];
        smooth = (acc_sh > 17'(sscu_pkg::ONE_Q15)) ? sscu_pkg::ONE_Q15 : acc_sh[15:0];
    end

    always_comb
    begin
        if (clr_reg)
        begin
            we    = 1'b1;
            waddr = clr_addr_reg;
            wdata = '0;
        end
        else
        begin
            we    = back_en && b1_v_reg && (b1_reg.kind != sscu_pkg::KIND_IGNORE);
            waddr = b1_reg.bin[AW-1:0];
            wdata = (b1_reg.kind == sscu_pkg::KIND_NORMAL) ? smooth : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            store[waddr] <= wdata;
        if (pop)
        begin
            rd_reg  <= store[raddr];
            hit_reg <= we && (waddr == raddr);
            byp_reg <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= 1'b1;
            clr_addr_reg  <= '0;
            b1_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_reg)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1))
                    clr_reg <= 1'b0;
            end
            if (back_en)
            begin
                b1_v_reg      <= pop;
                out_valid_reg <= b1_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (back_en)
        begin
            b1_reg       <= q_item;
            out_bin_reg  <= b1_reg.bin;
            out_last_reg <= b1_reg.last;
            if (b1_reg.kind == sscu_pkg::KIND_NORMAL)
            begin
                out_coh_reg <= smooth;
                out_zp_reg  <= b1_reg.zero_power;
            end
            else
            begin
                out_coh_reg <= '0;
                out_zp_reg  <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_bin   = out_bin_reg;
    assign out_coh   = out_coh_reg;
    assign out_zp    = out_zp_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== rtl/smoothed_spectral_coherence_unit.sv =====
// top level of the smoothed spectral coherence unit
// depends on sscu_pkg, sscu_front, sscu_queue, sscu_back and the assertion header
//
//  channel  dir  signals                            contents
//  s_axis   in   tvalid tready tdata tlast          one bin of cross and power spectra
//  m_axis   out  tvalid tready tdata tuser tlast    smoothed coherence of that bin
//  cfg      in   cfg_we cfg_index cfg_data          new_weight, old_weight
//
// one bin per cycle sustained while m_axis_tready stays high; from accept to m_axis_tvalid
// an item passes three stages for abs, products and sum, the 15-stage divider,
// the queue and the back-end store read and output registers.
// after reset the store is cleared one entry a cycle (FFT_SIZE/2 entries, at
// most 2048); s_axis_tready stays low meanwhile.
// a stalled m_axis fills the 32-entry queue, then s_axis_tready drops.
module smoothed_spectral_coherence_unit #(
    parameter int FFT_SIZE = 4096
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // bin_index[10:0], cross_re[42:11], cross_im[74:43], power_left[106:75],
    // power_right[138:107], zero fill
    input  logic [143:0]  s_axis_tdata,
    input  logic          s_axis_tlast,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // out_bin[10:0], coherence[26:11], zero fill
    output logic [31:0]   m_axis_tdata,
    // zero_power[0]
    output logic          m_axis_tuser,
    output logic          m_axis_tlast,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [15:0]   cfg_data
);

    `include "smoothed_spectral_coherence_unit_assert.svh"

    logic [sscu_pkg::WEIGHT_W-1:0] nw_reg, ow_reg;
    sscu_pkg::back_stat_t          bstat;
    logic                          push_valid, q_valid;
    sscu_pkg::item_t               push_item, q_item;
    logic [sscu_pkg::BIN_W-1:0]    out_bin;
    logic [sscu_pkg::COH_W-1:0]    out_coh;
    logic                          out_zp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nw_reg <= sscu_pkg::ONE_Q15;
            ow_reg <= sscu_pkg::ONE_Q15;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sscu_pkg::CFG_NEW_WEIGHT: nw_reg <= cfg_data;
                sscu_pkg::CFG_OLD_WEIGHT: ow_reg <= cfg_data;
                default:                  nw_reg <= nw_reg;
            endcase
        end
    end

    sscu_front #(.FFT_SIZE(FFT_SIZE)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_bin     (s_axis_tdata[10:0]),
        .in_re      (s_axis_tdata[42:11]),
        .in_im      (s_axis_tdata[74:43]),
        .in_pl      (s_axis_tdata[106:75]),
        .in_pr      (s_axis_tdata[138:107]),
        .in_last    (s_axis_tlast),
        .bstat      (bstat),
        .push_valid (push_valid),
        .push_item  (push_item)
    );

    sscu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_item (push_item),
        .pop       (bstat.pop),
        .not_empty (q_valid),
        .head      (q_item)
    );

    sscu_back #(.FFT_SIZE(FFT_SIZE)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .new_weight (nw_reg),
        .old_weight (ow_reg),
        .bstat      (bstat),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_bin    (out_bin),
        .out_coh    (out_coh),
        .out_zp     (out_zp),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {5'b00000, out_coh, out_bin};
    assign m_axis_tuser = out_zp;

    `SSCU_ASSERT_IMPLY(a_clear_block, s_axis_tready, !bstat.clearing, "request taken during clear")
    `SSCU_ASSERT_IMPLY(a_coh_range, m_axis_tvalid, out_coh <= sscu_pkg::ONE_Q15, "coherence above one")
    `SSCU_ASSERT_IMPLY(a_bin_zero, m_axis_tvalid && out_bin == '0, out_coh == '0 && !out_zp, "bin zero set")
    `SSCU_ASSERT_NOW(a_pop_valid, !bstat.pop || q_valid, "pop from empty queue")

endmodule

// ===== test/sscu_checker.sv =====
// checker for the smoothed spectral coherence unit: watches both streams and the cfg port
// predicts each result from its own copy of the weights and the smoothed store; needs sscu_pkg
module sscu_checker #(
    parameter int FFT_SIZE = 4096
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [143:0] s_axis_tdata,
    input  logic         s_axis_tlast,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [31:0]  m_axis_tdata,
    input  logic         m_axis_tuser,
    input  logic         m_axis_tlast,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_data,
    output int           fail_count,
    output int           pending,
    output int           zero_power_seen,
    output int           saturated_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [sscu_pkg::BIN_W-1:0] bin;
        logic [sscu_pkg::COH_W-1:0] coh;
        logic                       zp;
        logic                       last;
    } coh_result_t;

    logic [sscu_pkg::COH_W-1:0]    smooth_mem [0:2047];
    logic [sscu_pkg::WEIGHT_W-1:0] w_new;
    logic [sscu_pkg::WEIGHT_W-1:0] w_old;
    coh_result_t                   coh_expected [$];

    // floor(num * 2^15 / den), saturated at one
    function automatic logic [sscu_pkg::COH_W-1:0] coh_ratio(logic [63:0] num, logic [63:0] den);
        logic [127:0] q;
        if (num >= den)
            return sscu_pkg::ONE_Q15;
        q = ({64'd0, num} << sscu_pkg::Q_BITS) / {64'd0, den};
        return q[sscu_pkg::COH_W-1:0];
    endfunction

    function automatic logic [31:0] mag32(logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    assign pending = coh_expected.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic [sscu_pkg::BIN_W-1:0] b;
        logic [63:0]                re, im, num, den, acc;
        logic [sscu_pkg::COH_W-1:0] raw;
        coh_result_t                r, got;
        if (!rst_n)
        begin
            for (int i = 0; i < 2048; i++)
                smooth_mem[i] = '0;
            w_new = 16'd32768;
            w_old = 16'd32768;
            coh_expected.delete();
            fail_count = 0;
            zero_power_seen = 0;
            saturated_seen = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == sscu_pkg::CFG_NEW_WEIGHT)
                    w_new = cfg_data;
                else
                    w_old = cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                b = s_axis_tdata[10:0];
                r = '0;
                r.bin = b;
                r.last = s_axis_tlast;
                if (b == 0)
                    smooth_mem[0] = '0;
                else if (b < FFT_SIZE / 2)
                begin
                    re = mag32(s_axis_tdata[42:11]);
                    im = mag32(s_axis_tdata[74:43]);
                    num = re * re + im * im;
                    den = {32'd0, s_axis_tdata[106:75]} * {32'd0, s_axis_tdata[138:107]};
                    if (den == 0)
                    begin
                        raw = '0;
                        r.zp = 1'b1;
                        zero_power_seen++;
                    end
                    else
                        raw = coh_ratio(num, den);
                    acc = ({48'd0, raw} * w_new + {48'd0, smooth_mem[b]} * w_old) >> 16;
                    if (acc > sscu_pkg::ONE_Q15)
                    begin
                        acc = sscu_pkg::ONE_Q15;
                        saturated_seen++;
                    end
                    smooth_mem[b] = acc[15:0];
                    r.coh = acc[15:0];
                end
                coh_expected.push_back(r);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.bin = m_axis_tdata[10:0];
                got.coh = m_axis_tdata[26:11];
                got.zp = m_axis_tuser;
                got.last = m_axis_tlast;
                if (coh_expected.size() == 0)
                begin
                    $error("unexpected result for bin %0d", got.bin);
                    fail_count++;
                end
                else
                begin
                    r = coh_expected.pop_front();
                    if (got.bin !== r.bin)
                    begin
                        $error("out_bin expected %0d got %0d", r.bin, got.bin);
                        fail_count++;
                    end
                    if (got.coh !== r.coh)
                    begin
                        $error("coherence expected %0d got %0d", r.coh, got.coh);
                        fail_count++;
                    end
                    if (got.zp !== r.zp)
                    begin
                        $error("zero_power expected %0d got %0d", r.zp, got.zp);
                        fail_count++;
                    end
                    if (got.last !== r.last)
                    begin
                        $error("out_last expected %0d got %0d", r.last, got.last);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

// ===== test/tb_smoothed_spectral_coherence_unit.sv =====
// testbench top for the smoothed spectral coherence unit: stimulus, weights, verdict
// depends on sscu_pkg, the unit itself and sscu_checker
module tb_smoothed_spectral_coherence_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FFT_SIZE = 4096;
    localparam int STALL_LIMIT = 20000;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [31:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;
    logic         cfg_we;
    logic         cfg_index;
    logic [15:0]  cfg_data;
    int           fail_count;
    int           pending;
    int           zero_power_seen;
    int           saturated_seen;
    int           idle_cycles;
    int           sent;
    bit           calm;

    smoothed_spectral_coherence_unit #(.FFT_SIZE(FFT_SIZE)) i_dut (.*);

    sscu_checker #(.FFT_SIZE(FFT_SIZE)) i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver backpressure in random bursts
    initial
    begin
        int n;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = $urandom_range(1, 8);
            m_axis_tready <= calm ? 1'b1 : $urandom_range(0, 1);
            repeat (n) @(posedge clk);
        end
    end

    // watchdog on cycles with no transfer
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else if (++idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // tvalid stays high after the accept until the next request or drain
    task automatic send_bin(logic [10:0] b, logic [31:0] re, logic [31:0] im,
                            logic [31:0] pl, logic [31:0] pr, logic last);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, pr, pl, im, re, b};
        s_axis_tlast <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sent++;
    endtask

    task automatic write_weight(logic idx, logic [15:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return $urandom_range(0, 65535);
            default: return $urandom;
        endcase
    endfunction

    // a frame of bins with correlated spectra so coherence spans its range
    task automatic send_frame(int nbins);
        logic [31:0] pl, pr, re, im;
        logic [10:0] b;
        for (int k = 0; k < nbins; k++)
        begin
            b = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 15);
            if ($urandom_range(0, 3) == 0)
            begin
                pl = pick_word();
                pr = pick_word();
                re = pick_word();
                im = pick_word();
            end
            else
            begin
                pl = $urandom_range(1, 65535);
                pr = $urandom_range(1, 65535);
                re = $urandom_range(0, pl) - (pl >> 1);
                im = $urandom_range(0, pr) - (pr >> 1);
                if ($urandom_range(0, 1))
                    re = -re;
            end
            send_bin(b, re, im, pl, pr, k == nbins - 1);
        end
    endtask

    initial
    begin
        calm = 1'b0;
        sent = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        cfg_we = 1'b0;
        cfg_index = sscu_pkg::CFG_NEW_WEIGHT;
        cfg_data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, bin zero, top bins, zero power, saturation
        send_bin(11'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'd1, 1'b0);
        send_bin(11'd1, 32'h8000_0000, 32'h8000_0000, 32'd1, 32'd1, 1'b0);
        send_bin(11'd1, 32'd3, 32'd4, 32'd0, 32'd9, 1'b0);
        send_bin(11'd2, 32'd3, 32'd4, 32'd5, 32'd5, 1'b0);
        send_bin(11'd2, 32'd3, 32'd4, 32'd5, 32'd6, 1'b0);
        send_bin(11'd3, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_bin(11'd2047, 32'd1, 32'd1, 32'd1, 32'd1, 1'b0);
        send_bin(11'd2046, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 1'b1);
        send_bin(11'd4, 32'd0, 32'd0, 32'd7, 32'hFFFF_FFFF, 1'b0);
        send_bin(11'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd2, 32'd1, 1'b1);
        drain();
        write_weight(sscu_pkg::CFG_NEW_WEIGHT, 16'hFFFF);
        write_weight(sscu_pkg::CFG_OLD_WEIGHT, 16'hFFFF);
        send_bin(11'd1, 32'd9, 32'd9, 32'd9, 32'd9, 1'b0);
        send_bin(11'd1, 32'd9, 32'd9, 32'd9, 32'd9, 1'b0);
        send_bin(11'd1, 32'd0, 32'd0, 32'd0, 32'd9, 1'b1);
        send_bin(11'd0, 32'd9, 32'd9, 32'd9, 32'd9, 1'b1);
        drain();
        write_weight(sscu_pkg::CFG_NEW_WEIGHT, 16'd0);
        write_weight(sscu_pkg::CFG_OLD_WEIGHT, 16'd0);
        send_bin(11'd1, 32'd9, 32'd9, 32'd9, 32'd9, 1'b1);
        drain();

        // random phases over several weight settings
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: write_weight(sscu_pkg::CFG_NEW_WEIGHT, 16'd32768);
                1: write_weight(sscu_pkg::CFG_OLD_WEIGHT, 16'd0);
                2: write_weight(sscu_pkg::CFG_NEW_WEIGHT, 16'hFFFF);
                default:
                begin
                    write_weight(sscu_pkg::CFG_NEW_WEIGHT, $urandom);
                    write_weight(sscu_pkg::CFG_OLD_WEIGHT, $urandom);
                end
            endcase
            if (ph == 7)
                calm = 1'b1;
            for (int f = 0; f < 9; f++)
                send_frame($urandom_range(8, 20));
            drain();
        end

        $display("sent %0d bins; zero power %0d, saturated %0d",
                 sent, zero_power_seen, saturated_seen);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
